@@ rtl/core/mpr_pkg.sv @@
// Shared types for the Ryser permanent block.
// Holds the controller-to-datapath command struct; no dependencies.
`default_nettype none
package mpr_pkg;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic wr_en;     // store one loaded element
		logic start;     // clear sums, accumulator, sign and flag
		logic step_init; // product back to 1.0, toggle subset parity
		logic upd;       // update one column sum, latch multiply operands
		logic add_row;   // row enters the subset (else it leaves)
		logic mul_lo;    // low 32-bit partial product
		logic mul_hi;    // high 32-bit partial product
		logic rnd;       // round, saturate, store product
		logic acc;       // add or subtract product into accumulator
		logic fin;       // final sign and output register load
		logic n_odd;     // matrix order is odd
	} cmd_t;

	localparam int unsigned ACC_BITS = 64;

endpackage
`default_nettype wire

@@ rtl/core/mpr_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module mpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/core/mpr_ctrl.sv @@
// Controller: load counter, subset walk in Gray-code order, column sequencing.
// Depends on mpr_pkg for the command struct.
`default_nettype none
module mpr_ctrl #(
	parameter int MAX_ORDER    = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [4:0]               cfg_wdata,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic                     in_last,
	input  wire logic                     out_busy,
	output mpr_pkg::cmd_t                 cmd,
	output logic [$clog2(MAX_ORDER*MAX_ORDER > 1 ? MAX_ORDER*MAX_ORDER : 2)-1:0] wr_addr,
	output logic [$clog2(MAX_ORDER*MAX_ORDER > 1 ? MAX_ORDER*MAX_ORDER : 2)-1:0] rd_addr,
	output logic [$clog2(MAX_ORDER > 1 ? MAX_ORDER : 2)-1:0] col
);
	import mpr_pkg::*;

	localparam int AW   = $clog2(MAX_ORDER*MAX_ORDER > 1 ? MAX_ORDER*MAX_ORDER : 2);
	localparam int CW   = $clog2(MAX_ORDER > 1 ? MAX_ORDER : 2);
	localparam int NW   = $clog2(MAX_ORDER + 1) + 1;
	localparam int SUBW = MAX_ORDER + 1;

	typedef enum logic [10:0] {
		ST_LOAD  = 11'b00000000001,
		ST_START = 11'b00000000010,
		ST_STEP  = 11'b00000000100,
		ST_RD    = 11'b00000001000,
		ST_UPD   = 11'b00000010000,
		ST_MUL0  = 11'b00000100000,
		ST_MUL1  = 11'b00001000000,
		ST_RND   = 11'b00010000000,
		ST_ACC   = 11'b00100000000,
		ST_FIN   = 11'b01000000000,
		ST_IDLE2 = 11'b10000000000
	} state_t;

	state_t             state_q;
	logic [4:0]         size_q;
	logic [AW:0]        load_cnt_q;
	logic [SUBW-1:0]    sub_q;
	logic [AW-1:0]      base_q;
	logic [CW-1:0]      col_q;
	logic               add_q;

	logic [NW-1:0]      n;
	logic [AW:0]        nn;
	logic [SUBW-1:0]    last_sub;
	logic [CW-1:0]      row;
	logic               row_enters;
	logic [SUBW:0]      sub_pad;
	logic               in_fire;

	// order in use, clamped to 1 .. MAX_ORDER
	always_comb begin
		if (size_q == 5'd0) begin
			n = NW'(1);
		end else if (32'(size_q) > 32'(MAX_ORDER)) begin
			n = NW'(MAX_ORDER);
		end else begin
			n = NW'(size_q);
		end
	end

	assign nn       = (AW+1)'(n) * (AW+1)'(n);
	assign last_sub = (SUBW'(1) << n) - SUBW'(1);

	// lowest set bit of the subset counter picks the row; next bit tells direction
	assign sub_pad = {1'b0, sub_q};
	always_comb begin
		row        = '0;
		row_enters = 1'b0;
		for (int i = SUBW - 1; i >= 0; i--) begin
			if (sub_pad[i]) begin
				row        = CW'(i);
				row_enters = ~sub_pad[i+1];
			end
		end
	end

	assign in_ready = (state_q == ST_LOAD);
	assign in_fire  = in_valid && in_ready;
	assign wr_addr  = load_cnt_q[AW-1:0];
	assign rd_addr  = base_q + AW'(col_q);
	assign col      = col_q;

	// commands
	always_comb begin
		cmd           = '0;
		cmd.wr_en     = in_fire && (load_cnt_q < nn);
		cmd.start     = (state_q == ST_START);
		cmd.step_init = (state_q == ST_STEP);
		cmd.upd       = (state_q == ST_UPD);
		cmd.add_row   = add_q;
		cmd.mul_lo    = (state_q == ST_MUL0);
		cmd.mul_hi    = (state_q == ST_MUL1);
		cmd.rnd       = (state_q == ST_RND);
		cmd.acc       = (state_q == ST_ACC);
		cmd.fin       = (state_q == ST_FIN) && !out_busy;
		cmd.n_odd     = n[0];
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 5'd4;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// state machine and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			load_cnt_q <= '0;
			sub_q      <= '0;
			base_q     <= '0;
			col_q      <= '0;
			add_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (load_cnt_q < nn) begin
							load_cnt_q <= load_cnt_q + (AW+1)'(1);
						end
						if (in_last) begin
							load_cnt_q <= '0;
							state_q    <= ST_START;
						end
					end
				end
				ST_START: begin
					sub_q   <= SUBW'(1);
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					base_q  <= AW'(row) * AW'(n);
					add_q   <= row_enters;
					col_q   <= '0;
					state_q <= ST_RD;
				end
				ST_RD:   state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_MUL0;
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_RND;
				ST_RND: begin
					if (NW'(col_q) == n - NW'(1)) begin
						state_q <= ST_ACC;
					end else begin
						col_q   <= col_q + CW'(1);
						state_q <= ST_RD;
					end
				end
				ST_ACC: begin
					if (sub_q == last_sub) begin
						state_q <= ST_FIN;
					end else begin
						sub_q   <= sub_q + SUBW'(1);
						state_q <= ST_STEP;
					end
				end
				ST_FIN: begin
					if (!out_busy) begin
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/mpr_dp.sv @@
// Datapath: matrix store, column sums, split multiplier, accumulator, output register.
// Depends on mpr_pkg and mpr_ram.
`default_nettype none
module mpr_dp #(
	parameter int MAX_ORDER     = 16,
	parameter int ELEMENT_BITS  = 16,
	parameter int FRACTION_BITS = 14
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  mpr_pkg::cmd_t                 cmd,
	input  wire logic [$clog2(MAX_ORDER*MAX_ORDER > 1 ? MAX_ORDER*MAX_ORDER : 2)-1:0] wr_addr,
	input  wire logic [ELEMENT_BITS-1:0]  wr_data,
	input  wire logic [$clog2(MAX_ORDER*MAX_ORDER > 1 ? MAX_ORDER*MAX_ORDER : 2)-1:0] rd_addr,
	input  wire logic [$clog2(MAX_ORDER > 1 ? MAX_ORDER : 2)-1:0] col,
	output logic                          out_busy,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [mpr_pkg::ACC_BITS-1:0]  out_perm,
	output logic                          out_flag
);
	import mpr_pkg::*;

	localparam int DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int EB    = ELEMENT_BITS;
	localparam int SW    = ELEMENT_BITS + $clog2(MAX_ORDER > 1 ? MAX_ORDER : 2) + 1;
	localparam int AB    = ACC_BITS;
	localparam int PW    = AB + SW;
	localparam int MW    = 32 + SW;
	localparam logic [PW-1:0] HALF =
		(FRACTION_BITS > 0) ? (PW'(1) << (FRACTION_BITS - 1)) : '0;
	localparam logic [AB-1:0] MAX_POS = {1'b0, {(AB-1){1'b1}}};
	localparam logic [AB-1:0] MAX_NEG = {1'b1, {(AB-1){1'b0}}};

	logic [EB-1:0]        rd_data;
	logic signed [SW-1:0] sum_q [MAX_ORDER];
	logic signed [SW-1:0] elem_ext;
	logic signed [SW-1:0] sum_new;
	logic [SW-1:0]        b_mag_q;
	logic [AB-1:0]        a_mag_q;
	logic                 neg_q;
	logic [PW-1:0]        pp_q;
	logic signed [AB-1:0] prod_q;
	logic signed [AB-1:0] acc_q;
	logic                 sign_q;
	logic                 flag_q;
	logic [31:0]          mul_a;
	logic [MW-1:0]        mul_p;
	logic [PW-1:0]        rnd_sum;
	logic [PW-1:0]        rnd_mag;
	logic [AB-1:0]        lim;
	logic                 rnd_ovf;
	logic [AB-1:0]        mag64;
	logic signed [AB:0]   acc_wide;
	logic                 acc_ovf;
	logic signed [AB-1:0] acc_sat;
	logic signed [AB-1:0] fin_val;
	logic                 fin_ovf;
	logic                 out_valid_q;
	logic [AB-1:0]        out_perm_q;
	logic                 out_flag_q;

	mpr_ram #(
		.WIDTH(EB),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// column sum update
	assign elem_ext = signed'({{(SW-EB){rd_data[EB-1]}}, rd_data});
	assign sum_new  = cmd.add_row ? sum_q[col] + elem_ext : sum_q[col] - elem_ext;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < MAX_ORDER; i++) begin
				sum_q[i] <= '0;
			end
		end else if (cmd.upd) begin
			sum_q[col] <= sum_new;
		end
	end

	// 32 x SW multiplier shared by both halves of the product magnitude
	assign mul_a = cmd.mul_hi ? a_mag_q[63:32] : a_mag_q[31:0];
	assign mul_p = MW'(mul_a) * MW'(b_mag_q);

	// rounding half away from zero on the magnitude, then saturation
	assign rnd_sum = pp_q + HALF;
	assign rnd_mag = rnd_sum >> FRACTION_BITS;
	assign lim     = neg_q ? MAX_NEG : MAX_POS;
	assign rnd_ovf = rnd_mag > PW'(lim);
	assign mag64   = rnd_ovf ? lim : rnd_mag[AB-1:0];

	// saturating accumulate
	assign acc_wide = sign_q ? {acc_q[AB-1], acc_q} - {prod_q[AB-1], prod_q}
	                         : {acc_q[AB-1], acc_q} + {prod_q[AB-1], prod_q};
	assign acc_ovf  = acc_wide[AB] != acc_wide[AB-1];
	assign acc_sat  = acc_ovf ? (acc_wide[AB] ? MAX_NEG : MAX_POS) : acc_wide[AB-1:0];

	// final (-1)^n
	assign fin_ovf = cmd.n_odd && (acc_q == MAX_NEG);
	assign fin_val = !cmd.n_odd ? acc_q : (fin_ovf ? MAX_POS : -acc_q);

	// product path
	always_ff @(posedge clk) begin
		if (cmd.step_init) begin
			prod_q <= AB'(1) << FRACTION_BITS;
		end else if (cmd.rnd) begin
			prod_q <= neg_q ? -mag64 : mag64;
		end
		if (cmd.upd) begin
			a_mag_q <= prod_q[AB-1] ? -prod_q : prod_q;
			b_mag_q <= sum_new[SW-1] ? -sum_new : sum_new;
			neg_q   <= prod_q[AB-1] ^ sum_new[SW-1];
		end
		if (cmd.mul_lo) begin
			pp_q <= PW'(mul_p);
		end else if (cmd.mul_hi) begin
			pp_q <= pp_q + (PW'(mul_p) << 32);
		end
	end

	// accumulator, parity and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			sign_q <= 1'b0;
			flag_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				acc_q  <= '0;
				sign_q <= 1'b0;
				flag_q <= 1'b0;
			end else begin
				if (cmd.step_init) begin
					sign_q <= ~sign_q;
				end
				if (cmd.rnd && rnd_ovf) begin
					flag_q <= 1'b1;
				end
				if (cmd.acc) begin
					acc_q <= acc_sat;
					if (acc_ovf) begin
						flag_q <= 1'b1;
					end
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_perm_q <= fin_val;
			out_flag_q <= flag_q | fin_ovf;
		end
	end

	assign out_busy  = out_valid_q;
	assign out_valid = out_valid_q;
	assign out_perm  = out_perm_q;
	assign out_flag  = out_flag_q;

endmodule
`default_nettype wire

@@ rtl/core/matrix_permanent_ryser.sv @@
// Top level of the Ryser permanent block: ports, controller and datapath.
// Depends on mpr_pkg, mpr_ctrl, mpr_dp (and mpr_ram below it).
//
//  group   | dir | fields
//  s_axis  | in  | tdata: element_value; tlast: last_element
//  m_axis  | out | tdata: permanent_value; tuser: overflow_flag
//  cfg     | in  | cfg_wdata: size_in_use
//
// Loading takes one item per cycle. After the last item the controller walks
// every nonempty subset: each column takes one store read, one sum update,
// two passes through the shared 32-bit multiplier and a rounding step.
// Input is stalled during the walk; a waiting result only delays the end of
// the next walk. Reset sets the order to 4 and clears control state.
`default_nettype none
module matrix_permanent_ryser #(
	parameter int MAX_ORDER     = 16,
	parameter int ELEMENT_BITS  = 16,
	parameter int FRACTION_BITS = 14
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [4:0]                          cfg_wdata,  // size_in_use
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [((ELEMENT_BITS+7)/8)*8-1:0]   s_tdata,    // element_value
	input  wire logic                                s_tlast,    // last_element
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [mpr_pkg::ACC_BITS-1:0]             m_tdata,    // permanent_value
	output logic                                     m_tuser     // overflow_flag
);
	import mpr_pkg::*;

	localparam int AW = $clog2(MAX_ORDER*MAX_ORDER > 1 ? MAX_ORDER*MAX_ORDER : 2);
	localparam int CW = $clog2(MAX_ORDER > 1 ? MAX_ORDER : 2);

	cmd_t          cmd;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] col;
	logic          out_busy;

	mpr_ctrl #(
		.MAX_ORDER   (MAX_ORDER)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_last  (s_tlast),
		.out_busy (out_busy),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr),
		.col      (col)
	);

	mpr_dp #(
		.MAX_ORDER    (MAX_ORDER),
		.ELEMENT_BITS (ELEMENT_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.wr_data  (s_tdata[ELEMENT_BITS-1:0]),
		.rd_addr  (rd_addr),
		.col      (col),
		.out_busy (out_busy),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_perm (m_tdata),
		.out_flag (m_tuser)
	);

endmodule
`default_nettype wire
